/* rtl/core/wmm_pkg.sv */
// Shared types, character codes and helpers of the wildcard mask matcher.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
package wmm_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_AT    = 8'h40;

  localparam int unsigned LIMIT_W = 10;
  localparam int unsigned COUNT_W = 11;
  localparam logic [LIMIT_W-1:0] CALL_LIMIT_RST = 10'd512;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

  localparam logic OP_MASK    = 1'b0;
  localparam logic OP_SUBJECT = 1'b1;

  typedef enum logic [1:0] {
    PH_FRESH = 2'd0,
    PH_FILL  = 2'd1,
    PH_DRAIN = 2'd2
  } phase_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic start;
    logic att;
    logic w_inc;
    logic w_inc2;
    logic s_inc;
    logic push;
    logic pop;
    logic set_out;
    logic out_match;
    logic out_tl;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic res_evt;
    logic res_tl;
    logic cnt_over;
    logic m0_zero;
    logic m0_star;
    logic m0_qmark;
    logic m1_bang;
    logic m1_at;
    logic sc_zero;
    logic sc_bang;
    logic sc_at;
    logic ch_eq;
    logic sp_zero;
    logic sp_full;
  } status_t;

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'd32;
    end
    return r;
  endfunction

endpackage

/* rtl/core/wmm_ram.sv */
// Generic RAM with one write port and two registered read ports.
// No dependencies.
`timescale 1ns / 1ps
module wmm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

/* rtl/core/wmm_ctrl.sv */
// Controller of the wildcard mask matcher: sequences loading and the match walk.
// Depends on wmm_pkg for the command and status structs.
`timescale 1ns / 1ps
module wmm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  wmm_pkg::status_t st_i,
  output wmm_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_FETCH, ST_ATT, ST_BANG, ST_SKIPB, ST_AT, ST_SKIPA,
    ST_LOOP, ST_STARS, ST_QMARK, ST_SCAN, ST_FAIL, ST_POP
  } state_e;

  state_e state_q, state_d, ret_q, ret_d;
  logic   outv_q, outv_d;
  logic   accept;

  assign in_ready_o  = (state_q == ST_IDLE) && (!outv_q || out_ready_i);
  assign out_valid_o = outv_q;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    ret_d   = ret_q;
    outv_d  = outv_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          if (st_i.res_evt) begin
            if (st_i.res_tl) begin
              cmd_o.set_out = 1'b1;
              cmd_o.out_tl  = 1'b1;
              outv_d        = 1'b1;
            end else begin
              cmd_o.start = 1'b1;
              state_d     = ST_ATT;
            end
          end
        end
      end
      ST_FETCH: state_d = ret_q;
      ST_ATT: begin
        cmd_o.att = 1'b1;
        if (st_i.cnt_over) begin
          state_d = ST_FAIL;
        end else begin
          state_d = ST_FETCH;
          ret_d   = ST_BANG;
        end
      end
      ST_BANG: begin
        if (st_i.m0_star && st_i.m1_bang) begin
          cmd_o.w_inc2 = 1'b1;
          state_d      = ST_FETCH;
          ret_d        = ST_SKIPB;
        end else begin
          state_d = ST_AT;
        end
      end
      ST_SKIPB: begin
        if (st_i.sc_zero) begin
          state_d = ST_FAIL;
        end else begin
          cmd_o.s_inc = 1'b1;
          state_d     = ST_FETCH;
          ret_d       = st_i.sc_bang ? ST_AT : ST_SKIPB;
        end
      end
      ST_AT: begin
        if (st_i.m0_star && st_i.m1_at) begin
          cmd_o.w_inc2 = 1'b1;
          state_d      = ST_FETCH;
          ret_d        = ST_SKIPA;
        end else begin
          state_d = ST_LOOP;
        end
      end
      ST_SKIPA: begin
        if (st_i.sc_zero) begin
          state_d = ST_FAIL;
        end else begin
          cmd_o.s_inc = 1'b1;
          state_d     = ST_FETCH;
          ret_d       = st_i.sc_at ? ST_LOOP : ST_SKIPA;
        end
      end
      ST_LOOP: begin
        if (st_i.m0_zero) begin
          if (st_i.sc_zero) begin
            cmd_o.set_out   = 1'b1;
            cmd_o.out_match = 1'b1;
            outv_d          = 1'b1;
            state_d         = ST_IDLE;
          end else begin
            state_d = ST_FAIL;
          end
        end else if (st_i.m0_star) begin
          cmd_o.w_inc = 1'b1;
          state_d     = ST_FETCH;
          ret_d       = ST_STARS;
        end else if (st_i.sc_zero || (!st_i.m0_qmark && !st_i.ch_eq)) begin
          state_d = ST_FAIL;
        end else begin
          cmd_o.w_inc = 1'b1;
          cmd_o.s_inc = 1'b1;
          state_d     = ST_FETCH;
          ret_d       = ST_LOOP;
        end
      end
      ST_STARS: begin
        if (st_i.m0_star) begin
          cmd_o.w_inc = 1'b1;
          state_d     = ST_FETCH;
          ret_d       = ST_STARS;
        end else begin
          state_d = ST_QMARK;
        end
      end
      ST_QMARK: begin
        if (st_i.m0_qmark && !st_i.sc_zero) begin
          cmd_o.w_inc = 1'b1;
          cmd_o.s_inc = 1'b1;
          state_d     = ST_FETCH;
          ret_d       = ST_QMARK;
        end else if (st_i.m0_zero) begin
          cmd_o.set_out   = 1'b1;
          cmd_o.out_match = 1'b1;
          outv_d          = 1'b1;
          state_d         = ST_IDLE;
        end else if (st_i.m0_star) begin
          state_d = ST_LOOP;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (st_i.sc_zero) begin
          state_d = ST_FAIL;
        end else if (!st_i.ch_eq || st_i.sp_full) begin
          cmd_o.s_inc = 1'b1;
          state_d     = ST_FETCH;
          ret_d       = ST_SCAN;
        end else begin
          // Candidate found: save it and start a nested attempt past it.
          cmd_o.push = 1'b1;
          state_d    = ST_ATT;
        end
      end
      ST_FAIL: begin
        if (st_i.sp_zero) begin
          cmd_o.set_out = 1'b1;
          outv_d        = 1'b1;
          state_d       = ST_IDLE;
        end else begin
          state_d = ST_POP;
        end
      end
      ST_POP: begin
        cmd_o.pop = 1'b1;
        state_d   = ST_FETCH;
        ret_d     = ST_SCAN;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
      outv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      outv_q  <= outv_d;
    end
  end

endmodule

/* rtl/core/wmm_dp.sv */
// Datapath of the wildcard mask matcher: string stores, positions, stack, counters.
// Depends on wmm_pkg and wmm_ram.
`timescale 1ns / 1ps
module wmm_dp #(
  parameter int unsigned MAX_LEN = 128
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wmm_pkg::LIMIT_W-1:0]   cfg_wdata_i,
  input  logic                          op_i,
  input  logic [7:0]                    char_i,
  input  logic                          last_i,
  input  wmm_pkg::cmd_t                 cmd_i,
  output wmm_pkg::status_t              st_o,
  output logic                          matched_o,
  output logic                          aborted_o,
  output logic                          too_long_o
);

  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam int unsigned PW = $clog2(MAX_LEN + 3);
  localparam logic [LW-1:0] MAXL = LW'(MAX_LEN);

  wmm_pkg::phase_e mph_q, sph_q;
  logic [LW-1:0] mlen_q, slen_q, sp_q;
  logic [1:0]    ovf_q;
  logic [PW-1:0] w_q, s_q;
  logic [wmm_pkg::COUNT_W-1:0] cnt_q;
  logic [wmm_pkg::LIMIT_W-1:0] limit_q;
  logic          abort_q;
  logic          matched_q, aborted_q, too_long_q;

  // Load decode for the item on the input.
  wmm_pkg::phase_e ph_cur, ph_nxt;
  logic [LW-1:0] len_cur, len_eff, len_nxt;
  logic          drain, store_ok, wr_en, ended;
  logic [1:0]    ovf_nxt, flag;

  always_comb begin
    ph_cur   = (op_i == wmm_pkg::OP_SUBJECT) ? sph_q : mph_q;
    len_cur  = (op_i == wmm_pkg::OP_SUBJECT) ? slen_q : mlen_q;
    flag     = (op_i == wmm_pkg::OP_SUBJECT) ? 2'b10 : 2'b01;
    drain    = (ph_cur == wmm_pkg::PH_DRAIN);
    len_eff  = (ph_cur == wmm_pkg::PH_FRESH) ? '0 : len_cur;
    ovf_nxt  = (ph_cur == wmm_pkg::PH_FRESH) ? (ovf_q & ~flag) : ovf_q;
    store_ok = len_eff < MAXL;
    wr_en    = 1'b0;
    ended    = 1'b0;
    len_nxt  = len_eff;
    ph_nxt   = wmm_pkg::PH_FILL;
    if (drain) begin
      ovf_nxt = ovf_q;
      len_nxt = len_cur;
      ph_nxt  = last_i ? wmm_pkg::PH_FRESH : wmm_pkg::PH_DRAIN;
    end else if (char_i == wmm_pkg::CH_NUL) begin
      ph_nxt = last_i ? wmm_pkg::PH_FRESH : wmm_pkg::PH_DRAIN;
      ended  = 1'b1;
    end else begin
      if (store_ok) begin
        wr_en   = 1'b1;
        len_nxt = len_eff + 1'b1;
      end else begin
        ovf_nxt = ovf_nxt | flag;
      end
      if (last_i) begin
        ph_nxt = wmm_pkg::PH_FRESH;
        ended  = 1'b1;
      end
    end
  end

  // Stores and backtrack stack.
  logic [7:0]      m_rd_a, m_rd_b, s_rd;
  logic [2*PW-1:0] stk_rd;
  logic [PW-1:0]   w_p1;

  assign w_p1 = w_q + 1'b1;

  wmm_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_mask_ram (
    .clk_i     (clk_i),
    .we_i      (cmd_i.load && wr_en && (op_i == wmm_pkg::OP_MASK)),
    .waddr_i   (len_eff[AW-1:0]),
    .wdata_i   (char_i),
    .raddr_a_i (w_q[AW-1:0]),
    .raddr_b_i (w_p1[AW-1:0]),
    .rdata_a_o (m_rd_a),
    .rdata_b_o (m_rd_b)
  );

  wmm_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_subj_ram (
    .clk_i     (clk_i),
    .we_i      (cmd_i.load && wr_en && (op_i == wmm_pkg::OP_SUBJECT)),
    .waddr_i   (len_eff[AW-1:0]),
    .wdata_i   (char_i),
    .raddr_a_i (s_q[AW-1:0]),
    .raddr_b_i (s_q[AW-1:0]),
    .rdata_a_o (s_rd),
    .rdata_b_o ()
  );

  logic [LW-1:0] sp_m1;
  assign sp_m1 = sp_q - 1'b1;

  wmm_ram #(.WIDTH(2 * PW), .DEPTH(MAX_LEN)) u_stack_ram (
    .clk_i     (clk_i),
    .we_i      (cmd_i.push),
    .waddr_i   (sp_q[AW-1:0]),
    .wdata_i   ({w_q, s_q}),
    .raddr_a_i (sp_m1[AW-1:0]),
    .raddr_b_i (sp_m1[AW-1:0]),
    .rdata_a_o (stk_rd),
    .rdata_b_o ()
  );

  // Characters at the current positions; beyond a length they read as zero.
  logic [7:0] m0, m1, sc;
  always_comb begin
    m0 = ({1'b0, w_q} < {1'b0, PW'(mlen_q)}) ? m_rd_a : wmm_pkg::CH_NUL;
    m1 = ({1'b0, w_p1} < {1'b0, PW'(mlen_q)}) ? m_rd_b : wmm_pkg::CH_NUL;
    sc = (s_q < PW'(slen_q)) ? s_rd : wmm_pkg::CH_NUL;
  end

  always_comb begin
    st_o.res_evt  = ended && (op_i == wmm_pkg::OP_SUBJECT);
    st_o.res_tl   = ovf_nxt != 2'b00;
    st_o.cnt_over = cnt_q > {1'b0, limit_q};
    st_o.m0_zero  = m0 == wmm_pkg::CH_NUL;
    st_o.m0_star  = m0 == wmm_pkg::CH_STAR;
    st_o.m0_qmark = m0 == wmm_pkg::CH_QMARK;
    st_o.m1_bang  = m1 == wmm_pkg::CH_BANG;
    st_o.m1_at    = m1 == wmm_pkg::CH_AT;
    st_o.sc_zero  = sc == wmm_pkg::CH_NUL;
    st_o.sc_bang  = sc == wmm_pkg::CH_BANG;
    st_o.sc_at    = sc == wmm_pkg::CH_AT;
    st_o.ch_eq    = wmm_pkg::to_upper(sc) == wmm_pkg::to_upper(m0);
    st_o.sp_zero  = sp_q == '0;
    st_o.sp_full  = sp_q >= MAXL;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mph_q   <= wmm_pkg::PH_FRESH;
      sph_q   <= wmm_pkg::PH_FRESH;
      mlen_q  <= '0;
      slen_q  <= '0;
      ovf_q   <= '0;
      cnt_q   <= '0;
      limit_q <= wmm_pkg::CALL_LIMIT_RST;
      abort_q <= 1'b0;
      sp_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        ovf_q <= ovf_nxt;
        if (op_i == wmm_pkg::OP_SUBJECT) begin
          sph_q  <= ph_nxt;
          slen_q <= len_nxt;
        end else begin
          mph_q  <= ph_nxt;
          mlen_q <= len_nxt;
        end
      end
      if (cmd_i.start) begin
        cnt_q   <= '0;
        abort_q <= 1'b0;
        sp_q    <= '0;
      end
      if (cmd_i.att) begin
        if (cnt_q > {1'b0, limit_q}) begin
          abort_q <= 1'b1;
        end
        if (cnt_q != wmm_pkg::COUNT_MAX) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (cmd_i.push) begin
        sp_q <= sp_q + 1'b1;
      end else if (cmd_i.pop) begin
        sp_q <= sp_m1;
      end
    end
  end

  // Positions and result fields carry no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      w_q <= '0;
      s_q <= '0;
    end else if (cmd_i.push) begin
      w_q <= w_p1;
      s_q <= s_q + 1'b1;
    end else if (cmd_i.pop) begin
      w_q <= stk_rd[2*PW-1:PW];
      s_q <= stk_rd[PW-1:0] + 1'b1;
    end else begin
      if (cmd_i.w_inc2) begin
        w_q <= w_q + PW'(2);
      end else if (cmd_i.w_inc) begin
        w_q <= w_p1;
      end
      if (cmd_i.s_inc) begin
        s_q <= s_q + 1'b1;
      end
    end
    if (cmd_i.set_out) begin
      matched_q  <= cmd_i.out_match;
      aborted_q  <= abort_q && !cmd_i.out_tl;
      too_long_q <= cmd_i.out_tl;
    end
  end

  assign matched_o  = matched_q;
  assign aborted_o  = aborted_q;
  assign too_long_o = too_long_q;

endmodule

/* rtl/core/wildcard_mask_match_unit.sv */
// Wildcard mask matcher: loading one byte a cycle while idle, match on subject end.
// A request that ends no subject is loaded and no match runs. A subject end with either
// string overlong has its result valid in the cycle after acceptance; a matched subject
// end starts each attempt, compares bytes, scans and backtracks, each step waiting for a
// store read. A waiting result holds off every request until it is taken.
// Reset (async, active low) empties both strings, clears overflow and abort, limit is 512.
`timescale 1ns / 1ps
module wildcard_mask_match_unit #(
  parameter int unsigned MAX_LEN = 128
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [wmm_pkg::LIMIT_W-1:0] cfg_wdata_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // [7:0] char_byte
  input  logic                        s_axis_tuser,  // [0] operation
  input  logic                        s_axis_tlast,  // last_byte
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata   // [0] matched, [1] aborted, [2] too_long
);

  wmm_pkg::cmd_t    cmd;
  wmm_pkg::status_t st;
  logic matched, aborted, too_long;

  wmm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  wmm_dp #(.MAX_LEN(MAX_LEN)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .op_i        (s_axis_tuser),
    .char_i      (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .cmd_i       (cmd),
    .st_o        (st),
    .matched_o   (matched),
    .aborted_o   (aborted),
    .too_long_o  (too_long)
  );

  assign m_axis_tdata = {5'b0, too_long, aborted, matched};

endmodule
